### hdl/sclfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sclfr_pkg
// Shared types and constants of the length-prefixed frame receiver: result
// codes, the descriptor that passes from the byte front end to the dump
// engine, and the state type of the dump engine.
// ----------------------------------------------------------------------------
package sclfr_pkg;

    // Default frame buffer depth in bytes (one bank)
    localparam int BUF_DEPTH_DEF = 64;

    // Frame length field in a descriptor; covers depths up to 511
    localparam int LEN_W = 9;

    // Preamble and framing
    localparam logic [7:0] PRE0      = 8'hBB;
    localparam logic [7:0] PRE1      = 8'h00;
    localparam int         PRE_BYTES = 2;   // bytes held when the preamble is checked
    localparam int         HDR_BYTES = 8;   // bytes held when the length is known
    localparam int         FRAME_OVH = 10;  // header plus checksum bytes

    // Result kind carried in tuser
    typedef enum logic [1:0] {
        ST_GOOD = 2'd0,
        ST_CSUM = 2'd1,
        ST_LONG = 2'd2
    } status_t;

    // One finished frame or error, front end to dump engine
    typedef struct packed {
        status_t          status;
        logic             bank;
        logic [LEN_W-1:0] len;
    } desc_t;

    // Bank handed back by the dump engine
    typedef struct packed {
        logic valid;
        logic bank;
    } rel_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_DATA,
        BK_ERROR
    } back_state_t;

endpackage
`default_nettype wire

### hdl/sclfr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sclfr_front
// Byte front end: hunts for the preamble, reads the length, keeps the running
// sum and checks the trailing checksum. Writes bytes into the bank it owns and
// posts one descriptor per finished frame or error.
// ----------------------------------------------------------------------------
module sclfr_front #(
    parameter int BUFFER_DEPTH = sclfr_pkg::BUF_DEPTH_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [7:0]                   s_tdata,
    output logic                              wr_en,
    output logic [$clog2(BUFFER_DEPTH):0]     wr_addr,
    output logic [7:0]                        wr_data,
    output logic                              push,
    output sclfr_pkg::desc_t                  push_desc,
    input  wire logic                         q_full,
    input  sclfr_pkg::rel_t                   rel
);
    import sclfr_pkg::*;

    localparam int ADDR_W = $clog2(BUFFER_DEPTH);
    localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [15:0]       sum_reg, sum_next;
    logic [CNT_W-1:0]  exp_reg, exp_next;
    logic [7:0]        prev_reg, prev_next;
    logic              wbank_reg, wbank_next;
    logic [1:0]        busy_reg, busy_next;

    logic              accept;
    logic [CNT_W-1:0]  cnt_inc;
    logic [15:0]       sum_add;
    logic              pre_bad;
    logic [16:0]       tot;
    logic [15:0]       body;
    logic [15:0]       given;
    logic [ADDR_W-1:0] wr_idx;

    // Stall while the queue is full or the bank is still being dumped
    assign s_tready = !q_full && !busy_reg[wbank_reg];
    assign accept   = s_tvalid && s_tready;

    assign cnt_inc = cnt_reg + CNT_W'(1);
    assign sum_add = sum_reg + 16'(s_tdata);
    assign pre_bad = (prev_reg != PRE0) || (s_tdata != PRE1);
    assign tot     = 17'({s_tdata, prev_reg}) + 17'(FRAME_OVH);
    // sum of all bytes before the two checksum bytes
    assign body    = sum_reg - 16'(prev_reg);
    assign given   = {s_tdata, prev_reg};

    assign wr_en   = accept;
    assign wr_addr = {wbank_reg, wr_idx};
    assign wr_data = s_tdata;

    always_comb begin
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        exp_next   = exp_reg;
        prev_next  = prev_reg;
        wbank_next = wbank_reg;
        busy_next  = busy_reg;
        wr_idx     = cnt_reg[ADDR_W-1:0];
        push       = 1'b0;
        push_desc  = '{status: ST_GOOD, bank: wbank_reg, len: LEN_W'(cnt_inc)};

        if (rel.valid) begin
            busy_next[rel.bank] = 1'b0;
        end

        if (accept) begin
            prev_next = s_tdata;
            cnt_next  = cnt_inc;
            sum_next  = sum_add;
            if (cnt_inc == CNT_W'(PRE_BYTES)) begin
                if (pre_bad) begin
                    // slide: new byte becomes the first byte
                    cnt_next = CNT_W'(1);
                    wr_idx   = '0;
                end else begin
                    sum_next = 16'(PRE0) + 16'(PRE1);
                end
            end else if (cnt_inc == CNT_W'(HDR_BYTES)) begin
                exp_next = tot[CNT_W-1:0];
                if (tot > 17'(BUFFER_DEPTH)) begin
                    push             = 1'b1;
                    push_desc.status = ST_LONG;
                    cnt_next         = '0;
                    sum_next         = '0;
                end
            end else if (cnt_inc >= CNT_W'(FRAME_OVH) && cnt_inc == exp_reg) begin
                push     = 1'b1;
                cnt_next = '0;
                sum_next = '0;
                if (body == given) begin
                    wbank_next          = !wbank_reg;
                    busy_next[wbank_reg] = 1'b1;
                end else begin
                    push_desc.status = ST_CSUM;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            sum_reg   <= '0;
            exp_reg   <= '0;
            wbank_reg <= 1'b0;
            busy_reg  <= '0;
        end else begin
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
            exp_reg   <= exp_next;
            wbank_reg <= wbank_next;
            busy_reg  <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        prev_reg <= prev_next;
    end

    // A frame always closes before the bank fills
    a_cnt_below_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg < CNT_W'(BUFFER_DEPTH))
        else $error("front: byte count reached buffer depth");

    a_push_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_full)
        else $error("front: descriptor posted into a full queue");

endmodule
`default_nettype wire

### hdl/sclfr_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sclfr_queue
// Two-entry descriptor queue between the byte front end and the dump engine.
// ----------------------------------------------------------------------------
module sclfr_queue (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  sclfr_pkg::desc_t push_desc,
    output logic             full,
    input  wire logic        pop,
    output sclfr_pkg::desc_t pop_desc,
    output logic             empty
);
    import sclfr_pkg::*;

    desc_t       ent_reg [2];
    logic        wptr_reg, wptr_next;
    logic        rptr_reg, rptr_next;
    logic [1:0]  cnt_reg, cnt_next;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign pop_desc = ent_reg[rptr_reg];

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push) begin
            wptr_next = !wptr_reg;
        end
        if (pop) begin
            rptr_next = !rptr_reg;
        end
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wptr_reg] <= push_desc;
        end
    end

    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("queue: pop from an empty queue");

endmodule
`default_nettype wire

### hdl/sclfr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sclfr_back
// Dump engine: holds the two-bank frame buffer, takes descriptors from the
// queue and plays a good frame out byte by byte, or one error beat.
// ----------------------------------------------------------------------------
module sclfr_back #(
    parameter int BUFFER_DEPTH = sclfr_pkg::BUF_DEPTH_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         wr_en,
    input  wire logic [$clog2(BUFFER_DEPTH):0] wr_addr,
    input  wire logic [7:0]                   wr_data,
    input  wire logic                         q_empty,
    input  sclfr_pkg::desc_t                  q_desc,
    output logic                              pop,
    output sclfr_pkg::rel_t                   rel,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [15:0]                       m_tdata,
    output logic [1:0]                        m_tuser,
    output logic                              m_tlast
);
    import sclfr_pkg::*;

    localparam int ADDR_W = $clog2(BUFFER_DEPTH);
    localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);

    logic [7:0]        mem [2**(ADDR_W+1)];
    logic [7:0]        rd_data_reg;
    logic [ADDR_W:0]   rd_addr;

    back_state_t       state_reg, state_next;
    desc_t             desc_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic              last_beat;
    logic              beat_done;

    assign rd_addr   = {desc_reg.bank, idx_reg};
    assign last_beat = (CNT_W'(idx_reg) + CNT_W'(1)) == desc_reg.len[CNT_W-1:0];
    assign beat_done = (state_reg == BK_DATA) && m_tready;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (!q_empty) begin
                    state_next = (q_desc.status == ST_GOOD) ? BK_READ : BK_ERROR;
                end
            end
            BK_READ: begin
                state_next = BK_DATA;
            end
            BK_DATA: begin
                if (m_tready) begin
                    state_next = last_beat ? BK_IDLE : BK_READ;
                end
            end
            BK_ERROR: begin
                if (m_tready) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        pop       = 1'b0;
        m_tvalid  = 1'b0;
        m_tdata   = '0;
        m_tuser   = ST_GOOD;
        m_tlast   = 1'b0;
        rel.valid = 1'b0;
        rel.bank  = desc_reg.bank;
        unique case (state_reg)
            BK_IDLE: begin
                pop = !q_empty;
            end
            BK_READ: begin
            end
            BK_DATA: begin
                m_tvalid  = 1'b1;
                m_tdata   = {2'b00, 6'(idx_reg), rd_data_reg};
                m_tlast   = last_beat;
                rel.valid = m_tready && last_beat;
            end
            BK_ERROR: begin
                m_tvalid = 1'b1;
                m_tuser  = desc_reg.status;
                m_tlast  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            desc_reg <= q_desc;
            idx_reg  <= '0;
        end else if (beat_done && !last_beat) begin
            idx_reg  <= idx_reg + ADDR_W'(1);
        end
    end

    a_error_beat_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_GOOD) |-> (m_tlast && m_tdata == '0))
        else $error("back: error beat without last or with data");

endmodule
`default_nettype wire

### hdl/sync_length_checksum_frame_receiver_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sync_length_checksum_frame_receiver_core
// Receives bytes, finds preamble-framed, length-prefixed frames with a 16-bit
// additive checksum, and replays good frames byte by byte or reports errors.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | tdata (low bit up)              | tuser        | tlast
//  --------+-----+---------------------------------+--------------+------------
//  s_      | in  | rx_byte[7:0]                    | -            | -
//  m_      | out | frame_byte[7:0], byte_index[5:0] | status[1:0] | last
//
//  Pace: the front end takes one byte per cycle while s_tready is high. A good
//  frame plays out one beat at a time (buffer read, then the output register);
//  an error result is one beat. The single read port of the frame buffer sets
//  the output pace.
//  Stalls: s_tready drops while the descriptor queue is full or while the
//  bank the front end is filling is still being dumped. Two banks let the
//  next frame arrive while the previous one drains.
//  Reset: aresetn is synchronous; the frame buffer is not cleared, as only
//  bytes of the current frame are ever read.
//
module sync_length_checksum_frame_receiver_core #(
    parameter int BUFFER_DEPTH = sclfr_pkg::BUF_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input byte beats
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // rx_byte[7:0]
    // result beats
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,    // frame_byte[7:0], byte_index[13:8], zeros
    output logic [1:0]       m_tuser,    // status[1:0]
    output logic             m_tlast
);
    import sclfr_pkg::*;

    localparam int ADDR_W = $clog2(BUFFER_DEPTH);

    // buffer write port, front end to dump engine
    logic              wr_en;
    logic [ADDR_W:0]   wr_addr;
    logic [7:0]        wr_data;

    // descriptor queue
    logic              q_push;
    desc_t             q_push_desc;
    logic              q_full;
    logic              q_pop;
    desc_t             q_pop_desc;
    logic              q_empty;

    // bank hand-back
    rel_t              rel;

    // Classify bytes, check framing and checksum, fill the current bank
    sclfr_front #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .push      (q_push),
        .push_desc (q_push_desc),
        .q_full    (q_full),
        .rel       (rel)
    );

    // Hold finished-frame descriptors so each side can stall on its own
    sclfr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_desc (q_push_desc),
        .full      (q_full),
        .pop       (q_pop),
        .pop_desc  (q_pop_desc),
        .empty     (q_empty)
    );

    // Dump good frames from the buffer, emit error beats
    sclfr_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .q_empty   (q_empty),
        .q_desc    (q_pop_desc),
        .pop       (q_pop),
        .rel       (rel),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
`default_nettype wire

### tb/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the length-prefixed frame receiver. Builds frames
// with the 0xBB 0x00 preamble, a little-endian length and a 16-bit additive
// checksum, mixes in noise, bad checksums and oversize lengths, predicts every
// result beat in a scoreboard, and compares the beats that come out.
// ----------------------------------------------------------------------------
module tb_top;
    import sclfr_pkg::*;

    localparam int DEPTH        = BUF_DEPTH_DEF;
    localparam int MAX_PAYLOAD  = DEPTH - FRAME_OVH;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 200;
    localparam int PHASE_BYTES  = 12;

    // One result beat as the receiver sees it
    typedef struct packed {
        status_t    status;
        logic [7:0] data;
        logic [5:0] pos;
        logic       eof;
    } beat_t;

    // Tracks the frame being hunted and parsed, and queues the beats it owes
    class frame_scoreboard;
        logic [7:0]  held [DEPTH];
        int          held_cnt;
        logic [15:0] acc;
        logic [16:0] frame_total;
        beat_t       pending_beats [$];
        int          errors;

        function new();
            held_cnt    = 0;
            acc         = 0;
            frame_total = 0;
            errors      = 0;
            foreach (held[i]) held[i] = 8'h00;
        endfunction

        function void push_beat(status_t st, logic [7:0] d, int p, bit e);
            beat_t bt;
            bt.status = st;
            bt.data   = d;
            bt.pos    = p[5:0];
            bt.eof    = e;
            pending_beats.push_back(bt);
        endfunction

        function string fmt_beat(beat_t bt);
            return $sformatf("st=%0d data=%02h pos=%0d last=%0b",
                             bt.status, bt.data, bt.pos, bt.eof);
        endfunction

        // Advance the frame parser by one accepted byte
        function void note_rx_byte(logic [7:0] b);
            logic [15:0] body;
            logic [15:0] given;
            int          i;
            if (held_cnt < DEPTH) begin
                held[held_cnt] = b;
                held_cnt++;
            end
            acc = acc + 16'(b);
            if (held_cnt == PRE_BYTES) begin
                // slide by one byte on a preamble miss
                if (held[0] != PRE0 || held[1] != PRE1) begin
                    held[0]  = held[1];
                    held_cnt = 1;
                end else begin
                    acc = 16'(PRE0) + 16'(PRE1);
                end
            end else if (held_cnt == HDR_BYTES) begin
                frame_total = 17'({held[7], held[6]}) + 17'(FRAME_OVH);
                if (frame_total > DEPTH) begin
                    push_beat(ST_LONG, 8'h00, 0, 1'b1);
                    held_cnt = 0;
                    acc      = 0;
                end
            end else if (held_cnt > HDR_BYTES + 1 && held_cnt == frame_total) begin
                body  = acc - 16'(held[held_cnt-2]) - 16'(held[held_cnt-1]);
                given = {held[held_cnt-1], held[held_cnt-2]};
                if (body == given) begin
                    for (i = 0; i < held_cnt; i++)
                        push_beat(ST_GOOD, held[i], i, i + 1 == held_cnt);
                end else begin
                    push_beat(ST_CSUM, 8'h00, 0, 1'b1);
                end
                held_cnt = 0;
                acc      = 0;
            end
        endfunction

        function void check_beat(beat_t got);
            beat_t want;
            if (pending_beats.size() == 0) begin
                $display("%0t: result beat with none due: expected none, actual %s",
                         $time, fmt_beat(got));
                errors++;
                return;
            end
            want = pending_beats.pop_front();
            if (got.status !== want.status || got.data !== want.data ||
                got.pos !== want.pos || got.eof !== want.eof) begin
                $display("%0t: beat mismatch: expected %s, actual %s",
                         $time, fmt_beat(want), fmt_beat(got));
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    frame_scoreboard sb;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_req      = 0;
    int hold_left     = 0;
    int bytes_sent    = 0;
    int cycles        = 0;

    sync_length_checksum_frame_receiver_core #(
        .BUFFER_DEPTH(DEPTH)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: check each beat, then pick next cycle's ready
    always @(posedge aclk) begin
        beat_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = status_t'(m_tuser);
            got.data   = m_tdata[7:0];
            got.pos    = m_tdata[13:8];
            got.eof    = m_tlast;
            sb.check_beat(got);
        end
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offer one byte after a random gap and hold it until accepted
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_rx_byte(b);
        bytes_sent++;
    endtask

    // Send preamble, random header bytes and the length; for a length that
    // fits, follow with payload and checksum (flipped bits when corrupt)
    task automatic send_frame(input int unsigned plen, input bit corrupt);
        logic [7:0]  hdr [HDR_BYTES];
        logic [15:0] csum;
        logic [7:0]  b;
        int          i;
        hdr[0] = PRE0;
        hdr[1] = PRE1;
        for (i = 2; i < 6; i++) hdr[i] = 8'($urandom_range(255));
        hdr[6] = plen[7:0];
        hdr[7] = plen[15:8];
        csum = 16'h0000;
        for (i = 0; i < HDR_BYTES; i++) begin
            send_byte(hdr[i]);
            csum += 16'(hdr[i]);
        end
        if (plen + FRAME_OVH > DEPTH) return;
        for (i = 0; i < plen; i++) begin
            b = 8'($urandom_range(255));
            send_byte(b);
            csum += 16'(b);
        end
        if (corrupt) csum ^= 16'($urandom_range(16'hFFFF, 1));
        send_byte(csum[7:0]);
        send_byte(csum[15:8]);
    endtask

    // Mostly well-formed frames, with some errors and line noise
    task automatic send_random_unit();
        int r;
        int n;
        int i;
        r = $urandom_range(99);
        if (r < 55) begin
            send_frame($urandom_range(10), 1'b0);
        end else if (r < 68) begin
            send_frame(($urandom_range(3) == 0) ? MAX_PAYLOAD
                                                : $urandom_range(MAX_PAYLOAD, 30), 1'b0);
        end else if (r < 80) begin
            send_frame($urandom_range(12), 1'b1);
        end else if (r < 88) begin
            send_frame($urandom_range(1) ? $urandom_range(300, MAX_PAYLOAD + 1)
                                         : $urandom_range(16'hFFFF, MAX_PAYLOAD + 1), 1'b0);
        end else begin
            n = $urandom_range(4, 1);
            for (i = 0; i < n; i++) send_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic wait_drained();
        while (sb.pending_beats.size() != 0) @(posedge aclk);
    endtask

    initial begin
        int phase;
        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: noise, a doubled preamble start, shortest good frame,
        // bad checksum, largest length field, first oversize length
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(PRE0);
        send_frame(0, 1'b0);
        send_frame(0, 1'b1);
        send_frame(16'hFFFF, 1'b0);
        send_frame(MAX_PAYLOAD + 1, 1'b0);
        s_tvalid <= 1'b0;
        wait_drained();

        // Hold the result side off while frames keep coming, so both banks
        // fill and the input stalls; the first frame fills the buffer exactly
        hold_req = 300;
        send_frame(MAX_PAYLOAD, 1'b0);
        send_frame(2, 1'b0);
        send_frame(2, 1'b1);
        send_frame(2, 1'b0);
        s_tvalid <= 1'b0;
        wait_drained();

        // Random traffic under each idling mix; drain between mixes
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 64; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 64; end
                default: begin send_idle_pct = 33; stall_pct = 33; end
            endcase
            bytes_sent = 0;
            while (bytes_sent < PHASE_BYTES) send_random_unit();
            s_tvalid <= 1'b0;
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_beats.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
`default_nettype wire

### sim.f
hdl/sclfr_pkg.sv
hdl/sclfr_front.sv
hdl/sclfr_queue.sv
hdl/sclfr_back.sv
hdl/sync_length_checksum_frame_receiver_core.sv
tb/tb_top.sv
